// ----- hdl/tsa_pkg.sv -----
// Shared types and constants for the touch sample averager.
// Depends on nothing; the top level and the checker import it.
package tsa_pkg;

	localparam int DEPTH_DEF       = 4;
	localparam int SAMPLE_BITS_DEF = 10;
	localparam int THRESH_W        = 11;
	localparam int USER_W          = 3;

	localparam logic [THRESH_W-1:0] JUMP_THRESH_RST = 11'd64;
	localparam logic [THRESH_W-1:0] MOVE_THRESH_RST = 11'd16;

	typedef enum logic {
		REG_JUMP_THRESH = 1'b0,
		REG_MOVE_THRESH = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_STILL = 2'd1,
		ST_MOVED = 2'd2
	} status_t;

endpackage

// ----- hdl/tsa_ring.sv -----
// Sample ring storage: one synchronous memory of (x, y) pairs with a registered read.
// Per-entry valid bits make never-written entries read as zero; a read of the entry
// being written in the same cycle returns the new data. Uses no package items.
module tsa_ring #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 20,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// Write-first: a read that collides with the write sees the new pair.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			priority if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else if (valid_q[rd_addr]) begin
				rd_data_q <= mem[rd_addr];
			end else begin
				rd_data_q <= '0;
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/touch_sample_averager_top.sv -----
// Top level of the touch sample averager: sample ring, running sums, mean and press status.
// Depends on tsa_pkg and instantiates tsa_ring.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata {y, x}, tuser {touching}
//  m_*       out  m_tvalid/m_tready  tdata {avg_y, avg_x}, tuser {status, is_pressed}
//  cfg_*     in   cfg_we only        cfg_index selects the threshold, cfg_data its value
//
// One item is taken per clock when the output side keeps up; its result passes through
// stage 1, stage 2, stage 3 and the output register, where it can leave. The ring takes
// one read and one write per cycle: the read of the slot about to be overwritten is
// issued on the transfer, the write-back and running-sum update follow once stage 1
// moves into stage 2.
// Reset clears the ring's valid bits at once, so no clearing pass is needed.
// A stage holds only while the stage ahead of it is full and not moving, so bubbles
// are squeezed out and input is still taken while a finished result waits.
module touch_sample_averager_top #(
	parameter int DEPTH       = tsa_pkg::DEPTH_DEF,
	parameter int SAMPLE_BITS = tsa_pkg::SAMPLE_BITS_DEF,
	localparam int DATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input sample pairs.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [DATA_W-1:0]             s_tdata,   // sample_x, sample_y, zero pad
	input  logic                          s_tuser,   // touching
	// Averaged results.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [DATA_W-1:0]             m_tdata,   // avg_x, avg_y, zero pad
	output logic [tsa_pkg::USER_W-1:0]    m_tuser,   // is_pressed, touch_status[1:0]
	// Threshold writes.
	input  logic                          cfg_we,
	input  tsa_pkg::reg_index_t           cfg_index,
	input  logic [tsa_pkg::THRESH_W-1:0]  cfg_data
);
	import tsa_pkg::*;

	localparam int AW      = $clog2(DEPTH);
	localparam int FILL_W  = $clog2(DEPTH + 1);
	localparam int SUM_W   = SAMPLE_BITS + AW;
	localparam int DIST_W  = SAMPLE_BITS + 1;
	localparam int CMP_W   = (DIST_W > THRESH_W) ? DIST_W : THRESH_W;
	localparam int PAIR_W  = 2 * SAMPLE_BITS;
	// The mean is a multiply by a rounded-up reciprocal of DEPTH; with this shift the
	// quotient is exact for every sum that fits in SUM_W bits.
	localparam int RECIP_K = SUM_W + AW;
	localparam longint RECIP_L = ((longint'(1) << RECIP_K) + DEPTH - 1) / DEPTH;
	localparam logic [SUM_W:0] RECIP_M = RECIP_L[SUM_W:0];
	localparam int PROD_W  = 2 * SUM_W + 1;

	// Configuration registers.
	logic [THRESH_W-1:0] jump_thresh_q;
	logic [THRESH_W-1:0] move_thresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_thresh_q <= JUMP_THRESH_RST;
			move_thresh_q <= MOVE_THRESH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_JUMP_THRESH: jump_thresh_q <= cfg_data;
				REG_MOVE_THRESH: move_thresh_q <= cfg_data;
			endcase
		end
	end

	// Stage enables. Each stage loads when it is empty or the next one moves.
	logic v_s1, v_s2, v_s3, m_tvalid_q;
	logic en_out, en3, en2, en1, accept;

	assign en_out   = !m_tvalid_q || m_tready;
	assign en3      = !v_s3 || en_out;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;
	assign accept   = s_tvalid && en1;

	// Input decode and the fill decision, taken on the transfer itself so that the
	// next item already sees the updated fill level and newest pair.
	logic [SAMPLE_BITS-1:0] in_x, in_y;
	logic                   touching;

	assign in_x     = s_tdata[SAMPLE_BITS-1:0];
	assign in_y     = s_tdata[PAIR_W-1:SAMPLE_BITS];
	assign touching = s_tuser;

	logic [FILL_W-1:0]      fill_q, fill_d;
	logic [AW-1:0]          newest_slot_q, newest_slot_d, slot_d;
	logic                   pressed_q, pressed_d, store_d;
	logic [SAMPLE_BITS-1:0] newest_x_q, newest_y_q;
	logic [SAMPLE_BITS-1:0] jdx, jdy;
	logic [DIST_W-1:0]      jump_dist;
	logic                   jump;

	// newest_x_q/newest_y_q hold the last stored pair, the one that stage 1 writes into
	// the newest ring slot, so the jump test needs no memory read.
	assign jdx       = (in_x > newest_x_q) ? in_x - newest_x_q : newest_x_q - in_x;
	assign jdy       = (in_y > newest_y_q) ? in_y - newest_y_q : newest_y_q - in_y;
	assign jump_dist = DIST_W'(jdx) + DIST_W'(jdy);
	assign jump      = CMP_W'(jump_dist) >= CMP_W'(jump_thresh_q);

	always_comb begin
		fill_d        = fill_q;
		newest_slot_d = newest_slot_q;
		pressed_d     = pressed_q;
		slot_d        = newest_slot_q;
		store_d       = 1'b0;
		if (!touching) begin
			// Release empties the ring but leaves the slot contents in place.
			fill_d    = '0;
			pressed_d = 1'b0;
		end else begin
			store_d = 1'b1;
			priority if ((fill_q == '0) || jump) begin
				fill_d        = FILL_W'(1);
				slot_d        = '0;
				newest_slot_d = '0;
			end else if (fill_q < FILL_W'(DEPTH)) begin
				slot_d        = fill_q[AW-1:0];
				newest_slot_d = fill_q[AW-1:0];
				fill_d        = fill_q + FILL_W'(1);
			end else begin
				// Ring is full: overwrite the oldest slot and latch pressed.
				slot_d        = (newest_slot_q == AW'(DEPTH - 1)) ? '0
				                : newest_slot_q + AW'(1);
				newest_slot_d = slot_d;
				pressed_d     = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q        <= '0;
			newest_slot_q <= '0;
			pressed_q     <= 1'b0;
		end else if (accept) begin
			fill_q        <= fill_d;
			newest_slot_q <= newest_slot_d;
			pressed_q     <= pressed_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && store_d) begin
			newest_x_q <= in_x;
			newest_y_q <= in_y;
		end
	end

	// Stage 1: the ring read of the target slot is in flight.
	logic                   store_s1, pressed_s1;
	logic [AW-1:0]          slot_s1;
	logic [SAMPLE_BITS-1:0] x_s1, y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			store_s1   <= store_d;
			pressed_s1 <= pressed_d;
			slot_s1    <= slot_d;
			x_s1       <= in_x;
			y_s1       <= in_y;
		end
	end

	logic              ring_we;
	logic [PAIR_W-1:0] ring_rd;

	assign ring_we = en2 && v_s1 && store_s1;

	tsa_ring #(
		.DEPTH (DEPTH),
		.WIDTH (PAIR_W)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (en1),
		.rd_addr (slot_d),
		.rd_data (ring_rd),
		.wr_en   (ring_we),
		.wr_addr (slot_s1),
		.wr_data ({y_s1, x_s1})
	);

	// Running sums over all DEPTH slots: drop the overwritten pair, add the new one.
	logic [SUM_W-1:0] sum_x_q, sum_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
		end else if (ring_we) begin
			sum_x_q <= sum_x_q - SUM_W'(ring_rd[SAMPLE_BITS-1:0]) + SUM_W'(x_s1);
			sum_y_q <= sum_y_q - SUM_W'(ring_rd[PAIR_W-1:SAMPLE_BITS]) + SUM_W'(y_s1);
		end
	end

	// Stage 2: sums hold this item's totals; stage 3 registers the means.
	logic                   pressed_s2, pressed_s3;
	logic [PROD_W-1:0]      prod_x, prod_y;
	logic [SAMPLE_BITS-1:0] avg_x_s3, avg_y_s3;

	assign prod_x = PROD_W'(sum_x_q) * PROD_W'(RECIP_M);
	assign prod_y = PROD_W'(sum_y_q) * PROD_W'(RECIP_M);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			pressed_s2 <= pressed_s1;
		end
		if (en3) begin
			pressed_s3 <= pressed_s2;
			avg_x_s3   <= prod_x[RECIP_K +: SAMPLE_BITS];
			avg_y_s3   <= prod_y[RECIP_K +: SAMPLE_BITS];
		end
	end

	// Press status, evaluated as each result enters the output register.
	logic [SAMPLE_BITS-1:0] anchor_x_q, anchor_y_q;
	logic                   anchor_held_q, anchor_held_d;
	logic                   moved_q, moved_d, load_anchor;
	status_t                status_d;
	logic [SAMPLE_BITS-1:0] mdx, mdy;
	logic [DIST_W-1:0]      move_dist;

	assign mdx       = (anchor_x_q > avg_x_s3) ? anchor_x_q - avg_x_s3 : avg_x_s3 - anchor_x_q;
	assign mdy       = (anchor_y_q > avg_y_s3) ? anchor_y_q - avg_y_s3 : avg_y_s3 - anchor_y_q;
	assign move_dist = DIST_W'(mdx) + DIST_W'(mdy);

	always_comb begin
		status_d      = ST_IDLE;
		anchor_held_d = anchor_held_q;
		moved_d       = moved_q;
		load_anchor   = 1'b0;
		priority if (!pressed_s3) begin
			anchor_held_d = 1'b0;
		end else if (!anchor_held_q) begin
			// First pressed result: this mean becomes the anchor.
			load_anchor   = 1'b1;
			anchor_held_d = 1'b1;
			moved_d       = 1'b0;
			status_d      = ST_STILL;
		end else if (!moved_q && (CMP_W'(move_dist) < CMP_W'(move_thresh_q))) begin
			status_d = ST_STILL;
		end else begin
			// Once moved, the status sticks until the press ends.
			moved_d  = 1'b1;
			status_d = ST_MOVED;
		end
	end

	logic                   update;
	logic [SAMPLE_BITS-1:0] avg_x_q, avg_y_q;
	logic                   is_pressed_q;
	status_t                status_q;

	assign update = en_out && v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q    <= 1'b0;
			anchor_held_q <= 1'b0;
			moved_q       <= 1'b0;
		end else begin
			if (en_out) begin
				m_tvalid_q <= v_s3;
			end
			if (update) begin
				anchor_held_q <= anchor_held_d;
				moved_q       <= moved_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (update) begin
			avg_x_q      <= avg_x_s3;
			avg_y_q      <= avg_y_s3;
			is_pressed_q <= pressed_s3;
			status_q     <= status_d;
			if (load_anchor) begin
				anchor_x_q <= avg_x_s3;
				anchor_y_q <= avg_y_s3;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = DATA_W'({avg_y_q, avg_x_q});
	assign m_tuser  = {status_q, is_pressed_q};

endmodule

// ----- hdl/tsa_checker.sv -----
// Port-level assertions for the touch sample averager, bound to its top level.
// Depends on tsa_pkg and on touch_sample_averager_top for the bind.
module tsa_checker #(
	parameter int SAMPLE_BITS = tsa_pkg::SAMPLE_BITS_DEF,
	localparam int DATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [DATA_W-1:0]          m_tdata,
	input logic [tsa_pkg::USER_W-1:0] m_tuser
);
	import tsa_pkg::*;

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Without pressed the status must be idle.
	a_idle_unpressed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tuser[2:1] == ST_IDLE)
		else $error("press status reported without pressed flag");

	// An accepted transfer is followed by a valid result on the output.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##4 m_tvalid)
		else $error("accepted item did not reach the output in time");

endmodule

bind touch_sample_averager_top tsa_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tsa_checker (.*);
